/* rtl/core/annexb_nal_start_code_scanner_top_assert.svh */
// Assertion macros for the start code scanner
`ifndef ANNEXB_NAL_START_CODE_SCANNER_TOP_ASSERT_SVH
`define ANNEXB_NAL_START_CODE_SCANNER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, held off during reset
`define ANNB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, held off during reset
`define ANNB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/annb_pkg.sv */
// Types, codes and class lookup shared by the start code scanner
package annb_pkg;

  localparam logic       KIND_HDR  = 1'b0;
  localparam logic       KIND_END  = 1'b1;

  localparam logic [2:0] CLS_OTHER  = 3'd0;
  localparam logic [2:0] CLS_NONIDR = 3'd1;
  localparam logic [2:0] CLS_IDR    = 3'd2;
  localparam logic [2:0] CLS_SEI    = 3'd3;
  localparam logic [2:0] CLS_SPS    = 3'd4;
  localparam logic [2:0] CLS_PPS    = 3'd5;
  localparam int         NUM_CLASSES = 6;

  localparam logic [4:0] TYPE_NONIDR = 5'd1;
  localparam logic [4:0] TYPE_IDR    = 5'd5;
  localparam logic [4:0] TYPE_SEI    = 5'd6;
  localparam logic [4:0] TYPE_SPS    = 5'd7;
  localparam logic [4:0] TYPE_PPS    = 5'd8;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;
  localparam logic [1:0] ZRUN_MAX  = 2'd2;

  localparam int         OUT_DATA_W = 80;
  localparam int         Q_DEPTH    = 4;
  localparam int         Q_PTR_W    = 2;
  localparam int         Q_CNT_W    = 3;

  typedef struct packed {
    logic        record_kind;
    logic [4:0]  nal_type;
    logic [2:0]  nal_class;
    logic [31:0] byte_offset;
    logic        gop_start;
    logic [31:0] class_count;
    logic        last_in_run;
  } record_t;

  typedef struct packed {
    logic [1:0] num;
    record_t    first;
    record_t    second;
  } push_t;

  function automatic logic [2:0] class_of(input logic [4:0] nal_type);
    logic [2:0] cls;
    case (nal_type)
      TYPE_NONIDR: cls = CLS_NONIDR;
      TYPE_IDR:    cls = CLS_IDR;
      TYPE_SEI:    cls = CLS_SEI;
      TYPE_SPS:    cls = CLS_SPS;
      TYPE_PPS:    cls = CLS_PPS;
      default:     cls = CLS_OTHER;
    endcase
    return cls;
  endfunction

endpackage

/* rtl/core/annb_rec_queue.sv */
// Four-entry result queue taking up to two records per cycle
module annb_rec_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  annb_pkg::push_t                     push,
  output logic                                room,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // nal_type, nal_class, byte_offset, gop_start, class_count, zero pad
  output logic [annb_pkg::OUT_DATA_W-1:0]     out_tdata,
  // record_kind
  output logic                                out_tuser,
  output logic                                out_tlast
);

  annb_pkg::record_t                  mem_r [annb_pkg::Q_DEPTH];
  logic [annb_pkg::Q_PTR_W-1:0]       wptr_r, wptr_nxt;
  logic [annb_pkg::Q_PTR_W-1:0]       rptr_r, rptr_nxt;
  logic [annb_pkg::Q_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                               pop;
  annb_pkg::record_t                  head;

  assign pop        = out_tvalid & out_tready;
  assign out_tvalid = (cnt_r != '0);
  assign room       = (cnt_r <= annb_pkg::Q_CNT_W'(annb_pkg::Q_DEPTH - 2));
  assign head       = mem_r[rptr_r];

  assign out_tdata = {7'd0, head.class_count, head.gop_start, head.byte_offset,
                      head.nal_class, head.nal_type};
  assign out_tuser = head.record_kind;
  assign out_tlast = head.last_in_run;

  always_comb begin
    wptr_nxt = wptr_r + annb_pkg::Q_PTR_W'(push.num);
    rptr_nxt = rptr_r + annb_pkg::Q_PTR_W'(pop);
    cnt_nxt  = cnt_r + annb_pkg::Q_CNT_W'(push.num) - annb_pkg::Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wptr_r] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem_r[wptr_r + annb_pkg::Q_PTR_W'(1)] <= push.second;
    end
  end

endmodule

/* rtl/core/annexb_nal_start_code_scanner_top.sv */
// Annex B start code scanner: finds NAL headers, classes and counts units
// Each record is queued as its byte transfers and shown after those before it.
// Throughput: one byte per cycle; a header on the final byte gives two records.
// in_tready drops while the four-entry result queue holds more than two records.
// Synchronous active-low reset clears position, zero run, counters and queue.
// The final byte of a stream returns all scan state and counters to reset.
module annexb_nal_start_code_scanner_top #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // data_byte
  input  logic [7:0]                      in_tdata,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // nal_type, nal_class, byte_offset, gop_start, class_count, zero pad
  output logic [annb_pkg::OUT_DATA_W-1:0] out_tdata,
  // record_kind
  output logic                            out_tuser,
  output logic                            out_tlast
);

  `include "annexb_nal_start_code_scanner_top_assert.svh"

  logic [31:0]            pos_r, pos_nxt;
  logic [1:0]             zr_r, zr_nxt;
  logic                   exp_r, exp_nxt;
  logic [31:0]            off_r, off_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r [annb_pkg::NUM_CLASSES];
  logic [COUNT_WIDTH-1:0] cnt_nxt [annb_pkg::NUM_CLASSES];
  logic [COUNT_WIDTH-1:0] tot_r, tot_nxt;

  logic                   acc;
  logic [7:0]             in_byte;
  logic [4:0]             ntype;
  logic [2:0]             cls;
  logic [COUNT_WIDTH-1:0] cnt_sel;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] tot_inc;
  logic [COUNT_WIDTH-1:0] tot_after;
  logic [31:0]            cnt_rep;
  logic [31:0]            tot_rep;
  annb_pkg::record_t      hdr_rec;
  annb_pkg::record_t      end_rec;
  annb_pkg::push_t        push;
  logic                   room;

  assign acc       = in_tvalid & in_tready;
  assign in_tready = room;
  assign in_byte   = in_tdata;
  assign ntype     = in_byte[4:0];
  assign cls       = annb_pkg::class_of(ntype);
  assign cnt_sel   = cnt_r[cls];
  assign cnt_inc   = (&cnt_sel) ? cnt_sel : cnt_sel + COUNT_WIDTH'(1);
  assign tot_inc   = (&tot_r) ? tot_r : tot_r + COUNT_WIDTH'(1);
  assign tot_after = exp_r ? tot_inc : tot_r;

  // clamp reported counts to 32 bits
  generate
    if (COUNT_WIDTH > 32) begin : g_rep_wide
      assign cnt_rep = (|cnt_inc[COUNT_WIDTH-1:32]) ? '1 : cnt_inc[31:0];
      assign tot_rep = (|tot_after[COUNT_WIDTH-1:32]) ? '1 : tot_after[31:0];
    end else if (COUNT_WIDTH == 32) begin : g_rep_eq
      assign cnt_rep = cnt_inc;
      assign tot_rep = tot_after;
    end else begin : g_rep_narrow
      assign cnt_rep = {{(32-COUNT_WIDTH){1'b0}}, cnt_inc};
      assign tot_rep = {{(32-COUNT_WIDTH){1'b0}}, tot_after};
    end
  endgenerate

  always_comb begin
    hdr_rec.record_kind = annb_pkg::KIND_HDR;
    hdr_rec.nal_type    = ntype;
    hdr_rec.nal_class   = cls;
    hdr_rec.byte_offset = off_r;
    hdr_rec.gop_start   = (cls == annb_pkg::CLS_SPS);
    hdr_rec.class_count = cnt_rep;
    hdr_rec.last_in_run = ~in_tlast;

    end_rec.record_kind = annb_pkg::KIND_END;
    end_rec.nal_type    = '0;
    end_rec.nal_class   = annb_pkg::CLS_OTHER;
    end_rec.byte_offset = pos_r + 32'd1;
    end_rec.gop_start   = 1'b0;
    end_rec.class_count = tot_rep;
    end_rec.last_in_run = 1'b1;

    push.first  = exp_r ? hdr_rec : end_rec;
    push.second = end_rec;
    push.num    = acc ? (2'(exp_r) + 2'(in_tlast)) : 2'd0;
  end

  always_comb begin
    pos_nxt = pos_r;
    zr_nxt  = zr_r;
    exp_nxt = exp_r;
    off_nxt = off_r;
    tot_nxt = tot_r;
    for (int i = 0; i < annb_pkg::NUM_CLASSES; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    if (acc) begin
      if (exp_r) begin
        cnt_nxt[cls] = cnt_inc;
        tot_nxt      = tot_inc;
        exp_nxt      = 1'b0;
        zr_nxt       = '0;
      end else if (in_byte == annb_pkg::BYTE_ONE && zr_r == annb_pkg::ZRUN_MAX) begin
        off_nxt = pos_r - 32'd2;
        exp_nxt = 1'b1;
        zr_nxt  = '0;
      end else if (in_byte == annb_pkg::BYTE_ZERO) begin
        if (zr_r != annb_pkg::ZRUN_MAX) begin
          zr_nxt = zr_r + 2'd1;
        end
      end else begin
        zr_nxt = '0;
      end
      if (in_tlast) begin
        // end of stream: drop all scan state
        pos_nxt = '0;
        zr_nxt  = '0;
        exp_nxt = 1'b0;
        off_nxt = '0;
        tot_nxt = '0;
        for (int i = 0; i < annb_pkg::NUM_CLASSES; i++) begin
          cnt_nxt[i] = '0;
        end
      end else begin
        pos_nxt = pos_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      zr_r  <= '0;
      exp_r <= 1'b0;
      off_r <= '0;
      tot_r <= '0;
      for (int i = 0; i < annb_pkg::NUM_CLASSES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      pos_r <= pos_nxt;
      zr_r  <= zr_nxt;
      exp_r <= exp_nxt;
      off_r <= off_nxt;
      tot_r <= tot_nxt;
      for (int i = 0; i < annb_pkg::NUM_CLASSES; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  annb_rec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `ANNB_ASSERT_NEXT(a_last_gives_record, in_tvalid && in_tready && in_tlast, out_tvalid,
                    "no record pending after final byte transfer")
  `ANNB_ASSERT_NEXT(a_last_clears_state, in_tvalid && in_tready && in_tlast,
                    pos_r == 32'd0 && !exp_r && zr_r == 2'd0,
                    "scan state not cleared after final byte")
  `ANNB_ASSERT_NOW(a_hdr_no_zero_run, exp_r, zr_r == 2'd0,
                   "zero run held while a header byte is awaited")

endmodule

/* dv/tb_annexb_nal_start_code_scanner_top.sv */
// Self-checking stream testbench for the Annex B start code scanner top level
module tb_annexb_nal_start_code_scanner_top;

  typedef struct {
    logic [7:0] data;
    logic       is_last;
    bit         drain_first;
  } stream_byte_t;

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata   = '0;
  logic                            in_tlast   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [annb_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            out_tlast;

  stream_byte_t        byte_queue[$];
  annb_pkg::record_t   expected_records[$];

  logic [31:0]  scan_pos;
  logic [1:0]   zero_count;
  logic         header_due;
  logic [31:0]  code_pos;
  logic [31:0]  unit_count[annb_pkg::NUM_CLASSES];

  int           errors      = 0;
  int           bytes_sent  = 0;
  int           rx_count    = 0;
  int           hold_left   = 0;
  bit           hold_done   = 1'b0;
  int           quiet_cycles = 0;
  stream_byte_t next_byte;

  annexb_nal_start_code_scanner_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [2:0] class_for_type(input logic [4:0] t);
    case (t)
      annb_pkg::TYPE_NONIDR: return annb_pkg::CLS_NONIDR;
      annb_pkg::TYPE_IDR:    return annb_pkg::CLS_IDR;
      annb_pkg::TYPE_SEI:    return annb_pkg::CLS_SEI;
      annb_pkg::TYPE_SPS:    return annb_pkg::CLS_SPS;
      annb_pkg::TYPE_PPS:    return annb_pkg::CLS_PPS;
      default:               return annb_pkg::CLS_OTHER;
    endcase
  endfunction

  task automatic clear_scan_state();
    scan_pos   = '0;
    zero_count = '0;
    header_due = 1'b0;
    code_pos   = '0;
    for (int i = 0; i < annb_pkg::NUM_CLASSES; i++) unit_count[i] = '0;
  endtask

  task automatic expect_record(input annb_pkg::record_t rec);
    expected_records.insert(expected_records.size(), rec);
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic is_last);
    annb_pkg::record_t rec;
    logic [2:0]  cls;
    logic [31:0] total;
    logic [32:0] acc;
    if (header_due) begin
      cls = class_for_type(b[4:0]);
      if (unit_count[cls] != 32'hFFFF_FFFF) unit_count[cls] = unit_count[cls] + 32'd1;
      rec.record_kind = annb_pkg::KIND_HDR;
      rec.nal_type    = b[4:0];
      rec.nal_class   = cls;
      rec.byte_offset = code_pos;
      rec.gop_start   = (cls == annb_pkg::CLS_SPS);
      rec.class_count = unit_count[cls];
      rec.last_in_run = !is_last;
      expect_record(rec);
      header_due = 1'b0;
      zero_count = '0;
    end else if (b == annb_pkg::BYTE_ONE && zero_count >= annb_pkg::ZRUN_MAX) begin
      code_pos   = scan_pos - 32'd2;
      header_due = 1'b1;
      zero_count = '0;
    end else if (b == annb_pkg::BYTE_ZERO) begin
      if (zero_count < annb_pkg::ZRUN_MAX) zero_count = zero_count + 2'd1;
    end else begin
      zero_count = '0;
    end
    if (is_last) begin
      total = '0;
      for (int i = 0; i < annb_pkg::NUM_CLASSES; i++) begin
        acc   = {1'b0, total} + {1'b0, unit_count[i]};
        total = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
      end
      rec.record_kind = annb_pkg::KIND_END;
      rec.nal_type    = '0;
      rec.nal_class   = annb_pkg::CLS_OTHER;
      rec.byte_offset = scan_pos + 32'd1;
      rec.gop_start   = 1'b0;
      rec.class_count = total;
      rec.last_in_run = 1'b1;
      expect_record(rec);
      clear_scan_state();
    end else begin
      scan_pos = scan_pos + 32'd1;
    end
  endtask

  task automatic put(input logic [7:0] b, input logic is_last = 1'b0);
    stream_byte_t item;
    item.data        = b;
    item.is_last     = is_last;
    item.drain_first = 1'b0;
    byte_queue.insert(byte_queue.size(), item);
  endtask

  task automatic mark_drain(input int idx);
    stream_byte_t item;
    item             = byte_queue[idx];
    item.drain_first = 1'b1;
    byte_queue[idx]  = item;
  endtask

  function automatic logic [7:0] pick_header();
    logic [4:0] t;
    case ($urandom_range(0, 9))
      0:       t = annb_pkg::TYPE_NONIDR;
      1:       t = annb_pkg::TYPE_IDR;
      2:       t = annb_pkg::TYPE_SEI;
      3:       t = annb_pkg::TYPE_SPS;
      4:       t = annb_pkg::TYPE_PPS;
      default: t = 5'($urandom_range(0, 31));
    endcase
    return {3'($urandom_range(0, 7)), t};
  endfunction

  function automatic logic [7:0] pick_noise();
    case ($urandom_range(0, 3))
      0:       return annb_pkg::BYTE_ZERO;
      1:       return annb_pkg::BYTE_ONE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_random_stream();
    int units;
    int len;
    if ($urandom_range(0, 7) == 0) begin
      len = $urandom_range(1, 30);
      for (int i = 0; i < len; i++) put(pick_noise(), i == len - 1);
      return;
    end
    units = $urandom_range(1, 6);
    for (int u = 0; u < units; u++) begin
      if ($urandom_range(0, 3) == 0) put(annb_pkg::BYTE_ZERO);
      put(annb_pkg::BYTE_ZERO);
      put(annb_pkg::BYTE_ZERO);
      if (u == units - 1 && $urandom_range(0, 7) == 0) begin
        put(annb_pkg::BYTE_ONE, 1'b1);
        return;
      end
      put(annb_pkg::BYTE_ONE);
      len = $urandom_range(0, 12);
      put(pick_header(), u == units - 1 && len == 0);
      for (int i = 0; i < len; i++)
        put(($urandom_range(0, 5) == 0) ? annb_pkg::BYTE_ZERO : 8'($urandom_range(0, 255)),
            u == units - 1 && i == len - 1);
    end
  endtask

  function automatic bit tx_may_idle();
    return !(bytes_sent >= 300 && bytes_sent < 450);
  endfunction

  function automatic bit rx_may_idle();
    return !(rx_count >= 40 && rx_count < 70);
  endfunction

  task automatic check_record();
    annb_pkg::record_t want;
    logic [4:0]  got_type;
    logic [2:0]  got_class;
    logic [31:0] got_offset;
    logic        got_gop;
    logic [31:0] got_count;
    got_type   = out_tdata[4:0];
    got_class  = out_tdata[7:5];
    got_offset = out_tdata[39:8];
    got_gop    = out_tdata[40];
    got_count  = out_tdata[72:41];
    if (expected_records.size() == 0) begin
      $error("unexpected record: kind %0b type %0d offset %0d", out_tuser, got_type,
             got_offset);
      errors++;
      return;
    end
    want = expected_records.pop_front();
    if (out_tuser !== want.record_kind) begin
      $error("record_kind: expected %0b, got %0b", want.record_kind, out_tuser);
      errors++;
    end
    if (got_type !== want.nal_type) begin
      $error("nal_type: expected %0d, got %0d", want.nal_type, got_type);
      errors++;
    end
    if (got_class !== want.nal_class) begin
      $error("nal_class: expected %0d, got %0d", want.nal_class, got_class);
      errors++;
    end
    if (got_offset !== want.byte_offset) begin
      $error("byte_offset: expected %0d, got %0d", want.byte_offset, got_offset);
      errors++;
    end
    if (got_gop !== want.gop_start) begin
      $error("gop_start: expected %0b, got %0b", want.gop_start, got_gop);
      errors++;
    end
    if (got_count !== want.class_count) begin
      $error("class_count: expected %0d, got %0d", want.class_count, got_count);
      errors++;
    end
    if (out_tlast !== want.last_in_run) begin
      $error("last_in_run: expected %0b, got %0b", want.last_in_run, out_tlast);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        scan_byte(in_tdata, in_tlast);
        bytes_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (byte_queue.size() > 0
            && !(byte_queue[0].drain_first && expected_records.size() > 0)
            && !(tx_may_idle() && $urandom_range(0, 99) < 25)) begin
          next_byte = byte_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_byte.data;
          in_tlast  <= next_byte.is_last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_record();
        rx_count++;
      end
      if (!hold_done && rx_count >= 20) begin
        hold_left = 200;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= rx_may_idle() ? ($urandom_range(0, 99) >= 25) : 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= 3000) begin
        $display("annexb_nal_start_code_scanner_top regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int directed;
    clear_scan_state();

    // lone final byte
    put(8'hFF, 1'b1);
    // SPS, PPS after a four-byte code, zero header, IDR, header on final byte
    put(annb_pkg::BYTE_ZERO); put(annb_pkg::BYTE_ZERO); put(annb_pkg::BYTE_ONE);
    put(8'h67);
    put(annb_pkg::BYTE_ZERO); put(annb_pkg::BYTE_ZERO); put(annb_pkg::BYTE_ZERO);
    put(annb_pkg::BYTE_ONE); put(8'hE8);
    put(annb_pkg::BYTE_ZERO); put(annb_pkg::BYTE_ZERO); put(annb_pkg::BYTE_ONE);
    put(annb_pkg::BYTE_ZERO);
    put(annb_pkg::BYTE_ZERO); put(annb_pkg::BYTE_ONE);
    put(annb_pkg::BYTE_ZERO); put(annb_pkg::BYTE_ZERO); put(annb_pkg::BYTE_ONE);
    put(8'h65);
    put(annb_pkg::BYTE_ZERO); put(annb_pkg::BYTE_ZERO); put(annb_pkg::BYTE_ONE);
    put(8'hFF, 1'b1);
    // start code with no header before the end
    put(annb_pkg::BYTE_ZERO); put(annb_pkg::BYTE_ZERO); put(annb_pkg::BYTE_ONE, 1'b1);
    directed = byte_queue.size();

    while (byte_queue.size() < 700) add_random_stream();
    mark_drain(directed);
    mark_drain(400);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("annexb_nal_start_code_scanner_top regression: pass");
    end else begin
      $display("annexb_nal_start_code_scanner_top regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/annb_pkg.sv
rtl/core/annb_rec_queue.sv
rtl/core/annexb_nal_start_code_scanner_top.sv
dv/tb_annexb_nal_start_code_scanner_top.sv
